/* sv/ipatv_pkg.sv */
// Shared constants and types for the IP address text validator.
// Depends on nothing; used by ip_address_text_validator, ipatv_checker and tb.

package ipatv_pkg;

    // Character codes
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Field and state widths
    localparam int CHAR_W   = 8;
    localparam int DOT_W    = 3;
    localparam int COLON_W  = 4;
    localparam int LEN_W    = 3;
    localparam int DEC_W    = 10;
    localparam int PROD_W   = 14;
    localparam int TDATA_W  = 8;

    // Limits of the two address forms
    localparam logic [DEC_W-1:0]   V4_MAX_VALUE  = 10'd255;
    localparam logic [LEN_W-1:0]   V4_MAX_DIGITS = 3'd3;
    localparam logic [LEN_W-1:0]   V6_MAX_DIGITS = 3'd4;
    localparam logic [DOT_W-1:0]   V4_PARTS      = 3'd4;
    localparam logic [COLON_W-1:0] V6_PARTS      = 4'd8;
    localparam logic [LEN_W-1:0]   LEN_SAT       = 3'd5;
    localparam logic [DEC_W-1:0]   DEC_SAT       = 10'd999;

    // Verdict codes
    typedef enum logic [1:0] {
        VERDICT_IPV4    = 2'd0,
        VERDICT_IPV6    = 2'd1,
        VERDICT_NEITHER = 2'd2
    } verdict_t;

endpackage

/* sv/ip_address_text_validator.sv */
// IP address text validator: checks a character stream for IPv4 or IPv6 form.
// Depends on ipatv_pkg for character codes, limits and verdict codes.
// Throughput: one character per cycle; the input stalls only while both verdict
// entries (output + skid) are full. The verdict is registered on the master side:
// it goes to the output register, or to the skid entry while the output stalls.
// Reset clears the tracker and both result entries; the tracker also clears after each last char.

module ip_address_text_validator
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Character input: [7:0] char_code
    input  logic [ipatv_pkg::TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,   // last_char
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Verdict output: [1:0] verdict, [7:2] zero
    output logic [ipatv_pkg::TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);

    // Tracker state
    logic                              v4_failed_reg, v4_failed_next;
    logic                              v6_failed_reg, v6_failed_next;
    logic [ipatv_pkg::DOT_W-1:0]       dot_total_reg, dot_total_next;
    logic [ipatv_pkg::COLON_W-1:0]     colon_total_reg, colon_total_next;
    logic [ipatv_pkg::LEN_W-1:0]       part_length_reg, part_length_next;
    logic [ipatv_pkg::DEC_W-1:0]       part_decimal_reg, part_decimal_next;
    logic                              part_zero_reg, part_zero_next;

    // Result buffer
    ipatv_pkg::verdict_t               out_verdict_reg, skid_verdict_reg;
    logic                              out_valid_reg, skid_valid_reg;

    logic [ipatv_pkg::CHAR_W-1:0]      char_code;
    logic                              accept;
    logic                              push;
    logic                              pop;
    logic                              is_dec;
    logic                              is_hex;
    logic [ipatv_pkg::DEC_W-1:0]       digit;
    logic [ipatv_pkg::PROD_W-1:0]      dec_sum;
    logic                              v4_ok_cur;
    logic                              v6_ok_cur;
    logic                              v4_ok_new;
    logic                              v6_ok_new;
    ipatv_pkg::verdict_t               verdict;

    assign char_code = s_tdata[ipatv_pkg::CHAR_W-1:0];
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign push      = accept && s_tlast;
    assign pop       = out_valid_reg && m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ipatv_pkg::TDATA_W-2){1'b0}}, out_verdict_reg};

    // Classify the character
    always_comb
    begin
        is_dec = char_code inside {[8'h30:8'h39]};
        is_hex = char_code inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
        digit  = {2'b00, char_code - ipatv_pkg::CH_ZERO};
        dec_sum = {1'b0, part_decimal_reg, 3'b000} + {3'b000, part_decimal_reg, 1'b0}
                  + {4'd0, digit};
    end

    // Judge the part held in the tracker before this character
    always_comb
    begin
        v4_ok_cur = (part_length_reg != '0)
                    && (part_length_reg <= ipatv_pkg::V4_MAX_DIGITS)
                    && !((part_length_reg > 3'd1) && part_zero_reg)
                    && (part_decimal_reg <= ipatv_pkg::V4_MAX_VALUE);
        v6_ok_cur = (part_length_reg != '0)
                    && (part_length_reg <= ipatv_pkg::V6_MAX_DIGITS);
    end

    // Advance the tracker by one character
    always_comb
    begin
        v4_failed_next    = v4_failed_reg;
        v6_failed_next    = v6_failed_reg;
        dot_total_next    = dot_total_reg;
        colon_total_next  = colon_total_reg;
        part_length_next  = part_length_reg;
        part_decimal_next = part_decimal_reg;
        part_zero_next    = part_zero_reg;

        if (char_code == ipatv_pkg::CH_DOT)
        begin
            v6_failed_next = 1'b1;
            if (dot_total_reg < ipatv_pkg::V4_PARTS)
            begin
                dot_total_next = dot_total_reg + 3'd1;
            end
            if (!v4_ok_cur || (dot_total_next >= ipatv_pkg::V4_PARTS))
            begin
                v4_failed_next = 1'b1;
            end
            part_length_next  = '0;
            part_decimal_next = '0;
            part_zero_next    = 1'b0;
        end
        else if (char_code == ipatv_pkg::CH_COLON)
        begin
            v4_failed_next = 1'b1;
            if (colon_total_reg < ipatv_pkg::V6_PARTS)
            begin
                colon_total_next = colon_total_reg + 4'd1;
            end
            if (!v6_ok_cur || (colon_total_next >= ipatv_pkg::V6_PARTS))
            begin
                v6_failed_next = 1'b1;
            end
            part_length_next  = '0;
            part_decimal_next = '0;
            part_zero_next    = 1'b0;
        end
        else
        begin
            if (is_dec)
            begin
                if ((part_length_reg == '0) && (digit == '0))
                begin
                    part_zero_next = 1'b1;
                end
                if (dec_sum > {4'd0, ipatv_pkg::DEC_SAT})
                begin
                    part_decimal_next = ipatv_pkg::DEC_SAT;
                end
                else
                begin
                    part_decimal_next = dec_sum[ipatv_pkg::DEC_W-1:0];
                end
            end
            else
            begin
                v4_failed_next = 1'b1;
            end
            if (!is_hex)
            begin
                v6_failed_next = 1'b1;
            end
            if (part_length_reg < ipatv_pkg::LEN_SAT)
            begin
                part_length_next = part_length_reg + 3'd1;
            end
        end
    end

    // Judge the whole string from the updated tracker
    always_comb
    begin
        v4_ok_new = (part_length_next != '0)
                    && (part_length_next <= ipatv_pkg::V4_MAX_DIGITS)
                    && !((part_length_next > 3'd1) && part_zero_next)
                    && (part_decimal_next <= ipatv_pkg::V4_MAX_VALUE)
                    && !v4_failed_next
                    && (dot_total_next == ipatv_pkg::V4_PARTS - 3'd1);
        v6_ok_new = (part_length_next != '0)
                    && (part_length_next <= ipatv_pkg::V6_MAX_DIGITS)
                    && !v6_failed_next
                    && (colon_total_next == ipatv_pkg::V6_PARTS - 4'd1);
        if (v4_ok_new)
        begin
            verdict = ipatv_pkg::VERDICT_IPV4;
        end
        else if (v6_ok_new)
        begin
            verdict = ipatv_pkg::VERDICT_IPV6;
        end
        else
        begin
            verdict = ipatv_pkg::VERDICT_NEITHER;
        end
    end

    // Hold tracker state; clear it after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_failed_reg    <= 1'b0;
            v6_failed_reg    <= 1'b0;
            dot_total_reg    <= '0;
            colon_total_reg  <= '0;
            part_length_reg  <= '0;
            part_decimal_reg <= '0;
            part_zero_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                v4_failed_reg    <= 1'b0;
                v6_failed_reg    <= 1'b0;
                dot_total_reg    <= '0;
                colon_total_reg  <= '0;
                part_length_reg  <= '0;
                part_decimal_reg <= '0;
                part_zero_reg    <= 1'b0;
            end
            else
            begin
                v4_failed_reg    <= v4_failed_next;
                v6_failed_reg    <= v6_failed_next;
                dot_total_reg    <= dot_total_next;
                colon_total_reg  <= colon_total_next;
                part_length_reg  <= part_length_next;
                part_decimal_reg <= part_decimal_next;
                part_zero_reg    <= part_zero_next;
            end
        end
    end

    // Buffer verdicts: output register first, skid entry while output stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
            out_verdict_reg  <= ipatv_pkg::VERDICT_NEITHER;
            skid_verdict_reg <= ipatv_pkg::VERDICT_NEITHER;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_verdict_reg <= skid_verdict_reg;
                skid_valid_reg  <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_verdict_reg <= verdict;
                out_valid_reg   <= 1'b1;
            end
            else
            begin
                skid_verdict_reg <= verdict;
                skid_valid_reg   <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

/* tb/ipatv_checker.sv */
`timescale 1ns / 100ps
// Checker for the IP address text validator: watches the character and verdict
// streams, predicts each verdict from the accepted characters and compares.
// Depends on ipatv_pkg for widths, limits, character and verdict codes.

module ipatv_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Character stream: [7:0] char_code
    input  logic [ipatv_pkg::TDATA_W-1:0] char_tdata,
    input  logic                          char_tlast,   // last_char
    input  logic                          char_tvalid,
    input  logic                          char_tready,
    // Verdict stream: [1:0] verdict, [7:2] zero
    input  logic [ipatv_pkg::TDATA_W-1:0] verdict_tdata,
    input  logic                          verdict_tvalid,
    input  logic                          verdict_tready,
    output int                            mismatches,
    output int                            verdicts_pending,
    output int                            n_ipv4,
    output int                            n_ipv6,
    output int                            n_neither
);

    // Digit range bounds not covered by the package
    localparam logic [ipatv_pkg::CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [ipatv_pkg::CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [ipatv_pkg::CHAR_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [ipatv_pkg::CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [ipatv_pkg::CHAR_W-1:0] CH_LOWER_F = 8'h66;

    // Tracker state of the address currently being received
    logic                          v4_ruled_out;
    logic                          v6_ruled_out;
    logic [ipatv_pkg::DOT_W-1:0]   dot_cnt;
    logic [ipatv_pkg::COLON_W-1:0] colon_cnt;
    logic [ipatv_pkg::LEN_W-1:0]   seg_len;
    logic [ipatv_pkg::DEC_W-1:0]   seg_val;
    logic                          seg_lead_zero;

    ipatv_pkg::verdict_t expected_verdicts[$];

    function automatic logic seg_is_octet(input logic [ipatv_pkg::LEN_W-1:0] len,
                                          input logic [ipatv_pkg::DEC_W-1:0] val,
                                          input logic lead_zero);
        if (len == 0 || len > ipatv_pkg::V4_MAX_DIGITS)
            return 1'b0;
        if (len > 1 && lead_zero)
            return 1'b0;
        return val <= ipatv_pkg::V4_MAX_VALUE;
    endfunction

    function automatic logic seg_is_hextet(input logic [ipatv_pkg::LEN_W-1:0] len);
        return len != 0 && len <= ipatv_pkg::V6_MAX_DIGITS;
    endfunction

    task automatic clear_segment();
        seg_len       = '0;
        seg_val       = '0;
        seg_lead_zero = 1'b0;
    endtask

    task automatic reset_tracker();
        v4_ruled_out = 1'b0;
        v6_ruled_out = 1'b0;
        dot_cnt      = '0;
        colon_cnt    = '0;
        clear_segment();
    endtask

    // Update the tracker with one character; queue a verdict on the last one
    task automatic advance_tracker(input logic [ipatv_pkg::CHAR_W-1:0] c, input logic fin);
        logic [ipatv_pkg::PROD_W-1:0] scaled;
        logic                         dec_digit;
        logic                         hex_digit;
        logic                         v4_ok;
        logic                         v6_ok;
        dec_digit = (c >= ipatv_pkg::CH_ZERO) && (c <= CH_NINE);
        hex_digit = dec_digit || (c >= CH_UPPER_A && c <= CH_UPPER_F)
                    || (c >= CH_LOWER_A && c <= CH_LOWER_F);
        if (c == ipatv_pkg::CH_DOT)
        begin
            v6_ruled_out = 1'b1;
            if (!seg_is_octet(seg_len, seg_val, seg_lead_zero))
                v4_ruled_out = 1'b1;
            if (dot_cnt < ipatv_pkg::V4_PARTS)
                dot_cnt = dot_cnt + 1'b1;
            if (dot_cnt >= ipatv_pkg::V4_PARTS)
                v4_ruled_out = 1'b1;
            clear_segment();
        end
        else if (c == ipatv_pkg::CH_COLON)
        begin
            v4_ruled_out = 1'b1;
            if (!seg_is_hextet(seg_len))
                v6_ruled_out = 1'b1;
            if (colon_cnt < ipatv_pkg::V6_PARTS)
                colon_cnt = colon_cnt + 1'b1;
            if (colon_cnt >= ipatv_pkg::V6_PARTS)
                v6_ruled_out = 1'b1;
            clear_segment();
        end
        else
        begin
            if (dec_digit)
            begin
                scaled = ipatv_pkg::PROD_W'(seg_val) * ipatv_pkg::PROD_W'(10)
                         + ipatv_pkg::PROD_W'(c - ipatv_pkg::CH_ZERO);
                if (seg_len == 0 && c == ipatv_pkg::CH_ZERO)
                    seg_lead_zero = 1'b1;
                seg_val = (scaled > ipatv_pkg::PROD_W'(ipatv_pkg::DEC_SAT))
                          ? ipatv_pkg::DEC_SAT : scaled[ipatv_pkg::DEC_W-1:0];
            end
            else
                v4_ruled_out = 1'b1;
            if (!hex_digit)
                v6_ruled_out = 1'b1;
            if (seg_len < ipatv_pkg::LEN_SAT)
                seg_len = seg_len + 1'b1;
        end

        if (fin)
        begin
            v4_ok = !v4_ruled_out && dot_cnt == ipatv_pkg::V4_PARTS - 3'd1
                    && seg_is_octet(seg_len, seg_val, seg_lead_zero);
            v6_ok = !v6_ruled_out && colon_cnt == ipatv_pkg::V6_PARTS - 4'd1
                    && seg_is_hextet(seg_len);
            expected_verdicts.push_back(v4_ok ? ipatv_pkg::VERDICT_IPV4 :
                                        (v6_ok ? ipatv_pkg::VERDICT_IPV6
                                               : ipatv_pkg::VERDICT_NEITHER));
            reset_tracker();
        end
    endtask

    // Compare the verdict transaction first: a character accepted at the same
    // edge cannot have produced it yet
    always @(posedge clk)
    begin : monitor
        ipatv_pkg::verdict_t want;
        ipatv_pkg::verdict_t got;
        if (!rst_n)
        begin
            mismatches = 0;
            n_ipv4     = 0;
            n_ipv6     = 0;
            n_neither  = 0;
            reset_tracker();
            expected_verdicts.delete();
        end
        else
        begin
            if (verdict_tvalid && verdict_tready)
            begin
                got = ipatv_pkg::verdict_t'(verdict_tdata[1:0]);
                case (got)
                    ipatv_pkg::VERDICT_IPV4: n_ipv4++;
                    ipatv_pkg::VERDICT_IPV6: n_ipv6++;
                    default:                 n_neither++;
                endcase
                if (expected_verdicts.size() == 0)
                begin
                    $error("verdict: expected none, got %0d", verdict_tdata[1:0]);
                    mismatches++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (verdict_tdata[1:0] !== want)
                    begin
                        $error("verdict: expected %0d, got %0d", want, verdict_tdata[1:0]);
                        mismatches++;
                    end
                    if (verdict_tdata[ipatv_pkg::TDATA_W-1:2] !== '0)
                    begin
                        $error("padding: expected 0, got %0d",
                               verdict_tdata[ipatv_pkg::TDATA_W-1:2]);
                        mismatches++;
                    end
                end
            end
            if (char_tvalid && char_tready)
                advance_tracker(char_tdata, char_tlast);
        end
        verdicts_pending = expected_verdicts.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench top for the IP address text validator: clock, reset, address
// stimulus, output back-pressure and the verdict. Depends on ipatv_pkg,
// ip_address_text_validator and ipatv_checker.

module tb;

    localparam int CHAR_W       = ipatv_pkg::CHAR_W;
    localparam int TDATA_W      = ipatv_pkg::TDATA_W;
    localparam int RANDOM_CHARS = 1800;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_NS     = 3000000;

    logic               clk;
    logic               rst_n;
    logic [TDATA_W-1:0] s_tdata;
    logic               s_tlast;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tvalid;
    logic               m_tready;

    int mismatches;
    int verdicts_pending;
    int n_ipv4;
    int n_ipv6;
    int n_neither;

    // Stimulus bookkeeping
    logic [CHAR_W-1:0] addr[$];
    int   n_chars;
    int   n_addr;
    int   n_wellformed;
    int   hold_ticket;
    logic no_idle;

    string alphabet = "0123456789abcdefABCDEF.:g";
    string hex_lower = "0123456789abcdef";
    string hex_upper = "0123456789ABCDEF";

    ip_address_text_validator dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    ipatv_checker chk
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .char_tdata       (s_tdata),
        .char_tlast       (s_tlast),
        .char_tvalid      (s_tvalid),
        .char_tready      (s_tready),
        .verdict_tdata    (m_tdata),
        .verdict_tvalid   (m_tvalid),
        .verdict_tready   (m_tready),
        .mismatches       (mismatches),
        .verdicts_pending (verdicts_pending),
        .n_ipv4           (n_ipv4),
        .n_ipv6           (n_ipv6),
        .n_neither        (n_neither)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        #(LIMIT_NS);
        $display("ip_address_text_validator test failed");
        $finish;
    end

    // Offer one character; idle at random first, hold until accepted
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
        while (!no_idle && $urandom_range(0, 99) < 36)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= TDATA_W'($urandom_range(0, 255));
            s_tlast  <= 1'($urandom_range(0, 1));
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_addr();
        for (int i = 0; i < addr.size(); i++)
            send_char(addr[i], i == addr.size() - 1);
        n_addr++;
        n_chars += addr.size();
    endtask

    task automatic put_text(input string s);
        addr.delete();
        for (int i = 0; i < s.len(); i++)
            addr.push_back(s[i]);
    endtask

    // Stop offering and wait until every verdict has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (verdicts_pending != 0)
            @(negedge clk);
    endtask

    // Dotted decimal address; one part may be oversized
    task automatic build_v4(input int nparts, input bit oversize);
        int    wide_at;
        int    val;
        string digits;
        wide_at = oversize ? int'($urandom_range(0, nparts - 1)) : -1;
        for (int p = 0; p < nparts; p++)
        begin
            if (p != 0)
                addr.push_back(ipatv_pkg::CH_DOT);
            if (p == wide_at)
                val = $urandom_range(256, 9999999);
            else if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: val = 0;
                    1: val = 255;
                    2: val = 10;
                    default: val = 100;
                endcase
            end
            else
                val = $urandom_range(0, 255);
            digits = $sformatf("%0d", val);
            for (int i = 0; i < digits.len(); i++)
                addr.push_back(digits[i]);
        end
    endtask

    // Colon hex address in mixed case; one part may be too long
    task automatic build_v6(input int nparts, input bit oversize);
        int wide_at;
        int len;
        int d;
        wide_at = oversize ? int'($urandom_range(0, nparts - 1)) : -1;
        for (int p = 0; p < nparts; p++)
        begin
            if (p != 0)
                addr.push_back(ipatv_pkg::CH_COLON);
            len = (p == wide_at) ? $urandom_range(5, 7) : $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
            begin
                d = $urandom_range(0, 15);
                addr.push_back($urandom_range(0, 1) ? hex_upper[d] : hex_lower[d]);
            end
        end
    endtask

    // Receiver: random back-pressure, plus a long hold-off on request
    initial
    begin : sink
        int served;
        served   = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_ticket != served)
            begin
                served = hold_ticket;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= no_idle || ($urandom_range(0, 99) >= 36);
        end
    end

    // Sender and verdict
    initial
    begin : source
        int rand_chars;
        int idx;
        int kind;
        int fam;
        int mut;
        int np;
        int pos;
        int len;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        no_idle      = 1'b0;
        hold_ticket  = 0;
        n_chars      = 0;
        n_addr       = 0;
        n_wellformed = 0;
        rand_chars   = 0;
        idx          = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: all-zero dotted address, mixed-case hex, lone separators,
        // and a lone non-ASCII character
        put_text("0.0.0.0");
        send_addr();
        put_text("a:B:c:D:e:F:0:9");
        send_addr();
        put_text(".");
        send_addr();
        put_text(":");
        send_addr();
        addr.delete();
        addr.push_back(8'hFF);
        send_addr();
        wait_drained();

        // Random: a mix of mostly well-formed addresses, broken ones and noise
        while (rand_chars < RANDOM_CHARS)
        begin
            if (idx == 20)
                hold_ticket <= hold_ticket + 1;
            if (idx == 45)
                wait_drained();
            no_idle <= (idx >= 60 && idx < 90);
            addr.delete();
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                build_v4(4, 1'b0);
                n_wellformed++;
            end
            else if (kind < 55)
            begin
                build_v6(8, 1'b0);
                n_wellformed++;
            end
            else if (kind < 85)
            begin
                fam = $urandom_range(0, 1);
                mut = $urandom_range(0, 7);
                np  = (mut == 0) ? $urandom_range(1, 10) : (fam ? 8 : 4);
                if (fam)
                    build_v6(np, mut == 1);
                else
                    build_v4(np, mut == 1);
                pos = $urandom_range(0, addr.size() - 1);
                case (mut)
                    2: addr[pos] = CHAR_W'($urandom_range(0, 255));
                    3: addr[pos] = $urandom_range(0, 1) ? ipatv_pkg::CH_DOT
                                                        : ipatv_pkg::CH_COLON;
                    4: if (addr.size() > 1) addr.delete(pos);
                    5: addr.insert(pos, ipatv_pkg::CH_ZERO);
                    6: addr.push_back(fam ? ipatv_pkg::CH_COLON : ipatv_pkg::CH_DOT);
                    7: addr.insert(pos, alphabet[$urandom_range(0, alphabet.len() - 1)]);
                    default: ;
                endcase
            end
            else
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    addr.push_back($urandom_range(0, 1)
                                   ? CHAR_W'($urandom_range(0, 255))
                                   : alphabet[$urandom_range(0, alphabet.len() - 1)]);
            end
            send_addr();
            rand_chars += addr.size();
            idx++;
        end

        // Drain and report
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Run covered %0d characters in %0d addresses (%0d well-formed),",
                 n_chars, n_addr, n_wellformed);
        $display("with a long output stall and a full drain; %0s %0d IPv4, %0d IPv6, %0d neither.",
                 "verdicts", n_ipv4, n_ipv6, n_neither);
        if (mismatches == 0 && verdicts_pending == 0)
            $display("ip_address_text_validator test passed");
        else
            $display("ip_address_text_validator test failed");
        $finish;
    end

endmodule
